[design/fsc_pkg.sv]
// shared constants and types for the frustum sphere cull block
`default_nettype none

package fsc_pkg;

  localparam int FRAC_BITS_DEF = 16;

  // configuration port
  localparam int NUM_CFG   = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 64;

  // field widths
  localparam int ENT_W   = 32;
  localparam int COORD_W = 32;
  localparam int RAD_W   = 31;

  // matrix layout m[col][row]
  localparam int MAT_DIM = 4;
  localparam int ROW_W   = 3;
  localparam int COL_D   = 3;

  localparam int NUM_PLANES = 6;
  localparam int NUM_AXES   = 3;

  // plane arithmetic widths
  localparam int N_W    = ENT_W + 1;
  localparam int P_W    = N_W + COORD_W;
  localparam int SQ_W   = 2 * ENT_W + 1;
  localparam int S_W    = P_W + 2;
  localparam int NSQ_W  = SQ_W + 1;
  localparam int MAG_W  = S_W - 2;
  localparam int LO_W   = 32;
  localparam int HI_W   = MAG_W - LO_W;
  localparam int LHS_W  = 2 * MAG_W;
  localparam int R2_W   = 2 * RAD_W;
  localparam int RL_W   = R2_W / 2;
  localparam int RH_W   = R2_W - RL_W;
  localparam int NL_W   = NSQ_W / 2;
  localparam int NH_W   = NSQ_W - NL_W;
  localparam int RHS_W  = R2_W + NSQ_W;

  // pipeline stages
  localparam int PIPE_DEPTH = 8;
  localparam int ST_IN   = 0;
  localparam int ST_PROD = 1;
  localparam int ST_SUM  = 2;
  localparam int ST_MAG  = 3;
  localparam int ST_PART = 4;
  localparam int ST_WIDE = 5;
  localparam int ST_CMP  = 6;
  localparam int ST_OUT  = 7;

  typedef logic signed [ENT_W-1:0] entry_t;
  typedef entry_t [MAT_DIM-1:0][MAT_DIM-1:0] mat_t;
  typedef logic [PIPE_DEPTH-1:0] stage_en_t;

endpackage

`default_nettype wire

[design/fsc_if.sv]
// item channels: sphere input and cull result
`default_nettype none

interface fsc_in_if import fsc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] center_x;
  logic signed [COORD_W-1:0] center_y;
  logic signed [COORD_W-1:0] center_z;
  logic [RAD_W-1:0]          sphere_radius;

  modport source (output valid, center_x, center_y, center_z, sphere_radius, input ready);
  modport sink (input valid, center_x, center_y, center_z, sphere_radius, output ready);
endinterface

interface fsc_out_if ();
  logic valid;
  logic ready;
  logic visible;

  modport source (output valid, visible, input ready);
  modport sink (input valid, visible, output ready);
endinterface

`default_nettype wire

[design/fsc_plane.sv]
// one clip plane lane: plane distance and exact sphere-outside test
`default_nettype none

module fsc_plane import fsc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int AXIS      = 0,
  parameter bit MINUS     = 1'b0
) (
  input  logic                      clk,
  input  stage_en_t                 stage_en,
  input  mat_t                      mat,
  input  logic signed [COORD_W-1:0] cx,
  input  logic signed [COORD_W-1:0] cy,
  input  logic signed [COORD_W-1:0] cz,
  input  logic [R2_W-1:0]           r2,
  input  logic [RAD_W-1:0]          rad,
  output logic                      outside
);

  localparam logic [NSQ_W-1:0] EPS_SQ =
    NSQ_W'((67'd1 << (2 * FRAC_BITS)) / 67'd10000000000);

  logic signed [N_W-1:0]     n [NUM_AXES];
  logic signed [N_W-1:0]     d;
  logic signed [COORD_W-1:0] c [NUM_AXES];

  logic signed [P_W-1:0] prod [NUM_AXES];
  logic [SQ_W-1:0]       sq [NUM_AXES];

  logic signed [S_W-1:0] s_sum;
  logic [NSQ_W-1:0]      nsq_sum;

  logic              sneg_mag, short_mag;
  logic [MAG_W-1:0]  smag;
  logic [HI_W-1:0]   s_hi;
  logic [LO_W-1:0]   s_lo;
  logic [RH_W-1:0]   r_hi;
  logic [RL_W-1:0]   r_lo;
  logic [NH_W-1:0]   n_hi;
  logic [NL_W-1:0]   n_lo;
  logic [NSQ_W-1:0]  nsq_mag;

  logic                 sneg_part, short_part, scmp_part;
  logic [2*HI_W-1:0]    p_hh;
  logic [HI_W+LO_W-1:0] p_hl;
  logic [2*LO_W-1:0]    p_ll;
  logic [RH_W+NH_W-1:0] q_hh;
  logic [RH_W+NL_W-1:0] q_hl;
  logic [RL_W+NH_W-1:0] q_lh;
  logic [RL_W+NL_W-1:0] q_ll;

  logic             sneg_wide, short_wide, scmp_wide;
  logic [LHS_W-1:0] lhs;
  logic [RHS_W-1:0] rhs;

  // plane normal and offset straight from the matrix; user must keep it stable while items fly (not enforced)
  always_comb begin
    c[0] = cx;
    c[1] = cy;
    c[2] = cz;
    for (int i = 0; i < NUM_AXES; i++) begin
      if (MINUS) begin
        n[i] = N_W'(mat[i][ROW_W]) - N_W'(mat[i][AXIS]);
      end else begin
        n[i] = N_W'(mat[i][ROW_W]) + N_W'(mat[i][AXIS]);
      end
    end
    if (MINUS) begin
      d = N_W'(mat[COL_D][ROW_W]) - N_W'(mat[COL_D][AXIS]);
    end else begin
      d = N_W'(mat[COL_D][ROW_W]) + N_W'(mat[COL_D][AXIS]);
    end
  end

  assign s_hi = smag[MAG_W-1:LO_W];
  assign s_lo = smag[LO_W-1:0];
  assign r_hi = r2[R2_W-1:RL_W];
  assign r_lo = r2[RL_W-1:0];
  assign n_hi = nsq_mag[NSQ_W-1:NL_W];
  assign n_lo = nsq_mag[NL_W-1:0];

  always_ff @(posedge clk) begin
    if (stage_en[ST_PROD]) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        prod[i] <= P_W'(n[i]) * P_W'(c[i]);
        // square is non-negative, low bits hold it exactly
        sq[i]   <= SQ_W'(n[i]) * SQ_W'(n[i]);
      end
    end

    if (stage_en[ST_SUM]) begin
      s_sum   <= S_W'(prod[0]) + S_W'(prod[1]) + S_W'(prod[2])
               + (S_W'(d) <<< FRAC_BITS);
      nsq_sum <= NSQ_W'(sq[0]) + NSQ_W'(sq[1]) + NSQ_W'(sq[2]);
    end

    if (stage_en[ST_MAG]) begin
      sneg_mag  <= s_sum[S_W-1];
      smag      <= s_sum[S_W-1] ? MAG_W'(-s_sum) : MAG_W'(s_sum);
      short_mag <= (nsq_sum <= EPS_SQ);
      nsq_mag   <= nsq_sum;
    end

    // limb products for s^2 and r^2 * |n|^2
    if (stage_en[ST_PART]) begin
      sneg_part  <= sneg_mag;
      short_part <= short_mag;
      scmp_part  <= smag > (MAG_W'(rad) << FRAC_BITS);
      p_hh <= (2*HI_W)'(s_hi) * (2*HI_W)'(s_hi);
      p_hl <= (HI_W+LO_W)'(s_hi) * (HI_W+LO_W)'(s_lo);
      p_ll <= (2*LO_W)'(s_lo) * (2*LO_W)'(s_lo);
      q_hh <= (RH_W+NH_W)'(r_hi) * (RH_W+NH_W)'(n_hi);
      q_hl <= (RH_W+NL_W)'(r_hi) * (RH_W+NL_W)'(n_lo);
      q_lh <= (RL_W+NH_W)'(r_lo) * (RL_W+NH_W)'(n_hi);
      q_ll <= (RL_W+NL_W)'(r_lo) * (RL_W+NL_W)'(n_lo);
    end

    if (stage_en[ST_WIDE]) begin
      sneg_wide  <= sneg_part;
      short_wide <= short_part;
      scmp_wide  <= scmp_part;
      // cross term counted twice
      lhs <= (LHS_W'(p_hh) << (2 * LO_W)) + (LHS_W'(p_hl) << (LO_W + 1)) + LHS_W'(p_ll);
      rhs <= (RHS_W'(q_hh) << (RL_W + NL_W)) + (RHS_W'(q_hl) << RL_W)
           + (RHS_W'(q_lh) << NL_W) + RHS_W'(q_ll);
    end

    if (stage_en[ST_CMP]) begin
      outside <= sneg_wide && (short_wide ? scmp_wide : (lhs > LHS_W'(rhs)));
    end
  end

endmodule

`default_nettype wire

[design/frustum_sphere_cull_top.sv]
// frustum sphere cull top: config registers, pipeline control, six plane lanes
// an accepted item moves through stages in, prod, sum, mag, part, wide, cmp and out; out drives the result
// throughput: one sphere per cycle while the result side does not stall, through eight register stages
// the limb products of the plane test, 33x33 bits at most, set the stage depth
// stalls back up stage by stage; empty stages keep taking items while a result waits
// reset (synchronous, high) empties the pipeline and zeroes the matrix, so all spheres pass
`default_nettype none

module frustum_sphere_cull_top import fsc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  fsc_in_if.sink               sphere_in,
  fsc_out_if.source            result_out
);

  logic [CFG_W-1:0] cfg_reg [NUM_CFG];
  mat_t             mat;

  stage_en_t             stage_en;
  logic [PIPE_DEPTH-1:0] stage_vld;

  logic signed [COORD_W-1:0] cx, cy, cz;
  logic [RAD_W-1:0]          rad_in, rad_prod, rad_sum, rad_mag;
  logic [R2_W-1:0]           r2_prod, r2_sum, r2_mag;
  logic [NUM_PLANES-1:0]     outside;
  logic                      visible;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CFG; i++) begin
        cfg_reg[i] <= '0;
      end
    end else if (cfg_we) begin
      cfg_reg[cfg_index] <= cfg_wdata;
    end
  end

  // two entries per register, lower row in the low half
  always_comb begin
    for (int col = 0; col < MAT_DIM; col++) begin
      for (int row = 0; row < MAT_DIM; row++) begin
        mat[col][row] = cfg_reg[CFG_IDX_W'(2 * col + row / 2)][ENT_W * (row % 2) +: ENT_W];
      end
    end
  end

  // a stage takes new data when empty or when the next one moves
  always_comb begin
    stage_en[ST_OUT] = !stage_vld[ST_OUT] || result_out.ready;
    for (int i = PIPE_DEPTH - 2; i >= 0; i--) begin
      stage_en[i] = !stage_vld[i] || stage_en[i + 1];
    end
  end

  assign sphere_in.ready = stage_en[ST_IN];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_vld <= '0;
    end else begin
      for (int i = 0; i < PIPE_DEPTH; i++) begin
        if (stage_en[i]) begin
          stage_vld[i] <= (i == ST_IN) ? sphere_in.valid : stage_vld[(i + PIPE_DEPTH - 1) % PIPE_DEPTH];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[ST_IN]) begin
      cx     <= sphere_in.center_x;
      cy     <= sphere_in.center_y;
      cz     <= sphere_in.center_z;
      rad_in <= sphere_in.sphere_radius;
    end
    if (stage_en[ST_PROD]) begin
      r2_prod  <= R2_W'(rad_in) * R2_W'(rad_in);
      rad_prod <= rad_in;
    end
    if (stage_en[ST_SUM]) begin
      r2_sum  <= r2_prod;
      rad_sum <= rad_prod;
    end
    if (stage_en[ST_MAG]) begin
      r2_mag  <= r2_sum;
      rad_mag <= rad_sum;
    end
    if (stage_en[ST_OUT]) begin
      visible <= ~|outside;
    end
  end

  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
    fsc_plane #(
      .FRAC_BITS (FRAC_BITS),
      .AXIS      (p / 2),
      .MINUS     (p % 2 == 1)
    ) u_plane (
      .clk      (clk),
      .stage_en (stage_en),
      .mat      (mat),
      .cx       (cx),
      .cy       (cy),
      .cz       (cz),
      .r2       (r2_mag),
      .rad      (rad_mag),
      .outside  (outside[p])
    );
  end

  assign result_out.valid   = stage_vld[ST_OUT];
  assign result_out.visible = visible;

`ifndef SYNTH
  a_rst_empty: assert property (@(posedge clk) rst |=> !result_out.valid)
    else $error("result valid right after reset");

  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !sphere_in.ready |-> (&stage_vld) && !result_out.ready)
    else $error("input refused while pipeline has room");

  a_accept_load: assert property (@(posedge clk) disable iff (rst)
    sphere_in.valid && sphere_in.ready |=> stage_vld[ST_IN])
    else $error("accepted item not captured");

  a_hold_stage: assert property (@(posedge clk) disable iff (rst)
    (|(stage_vld & ~stage_en)) |=>
      ((stage_vld & $past(stage_vld & ~stage_en)) == $past(stage_vld & ~stage_en)))
    else $error("stalled stage lost its item");
`endif

endmodule

`default_nettype wire

[tb/fsc_cull_checker.sv]
// cull checker: watches config writes and both channels, predicts visibility, compares results
`timescale 1ns / 100ps

module fsc_cull_checker import fsc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  fsc_in_if                    sphere,
  fsc_out_if                   result,
  output int                   pending,
  output int                   fail_count
);

  // squared plane length at or below this is a degenerate plane
  localparam logic [255:0] SHORT_NSQ = (256'd1 << (2 * FRAC_BITS_DEF)) / 256'd10000000000;

  logic [CFG_W-1:0] matrix_regs [NUM_CFG];
  bit               visible_q [$];

  // m[col][row], lower row in the low half of each register
  function automatic logic signed [ENT_W-1:0] mat_entry(int col, int row);
    logic [CFG_W-1:0] r;
    r = matrix_regs[col * 2 + row / 2];
    return (row % 2) ? r[2*ENT_W-1:ENT_W] : r[ENT_W-1:0];
  endfunction

  function automatic bit sphere_in_view(logic signed [COORD_W-1:0] cx,
                                        logic signed [COORD_W-1:0] cy,
                                        logic signed [COORD_W-1:0] cz,
                                        logic [RAD_W-1:0] rad);
    logic signed [127:0] n [NUM_AXES];
    logic signed [127:0] cw [NUM_AXES];
    logic signed [127:0] d, s;
    logic [255:0]        s_mag, nsq, lhs, rhs, r2;
    bit                  minus, outside, seen;
    int                  k;
    cw[0] = cx;
    cw[1] = cy;
    cw[2] = cz;
    seen = 1'b1;
    for (int p = 0; p < NUM_PLANES; p++) begin
      k = p / 2;
      minus = (p % 2) != 0;
      for (int i = 0; i < NUM_AXES; i++) begin
        n[i] = minus ? mat_entry(i, 3) - mat_entry(i, k) : mat_entry(i, 3) + mat_entry(i, k);
      end
      d = minus ? mat_entry(3, 3) - mat_entry(3, k) : mat_entry(3, 3) + mat_entry(3, k);
      s = d <<< FRAC_BITS_DEF;
      nsq = '0;
      for (int i = 0; i < NUM_AXES; i++) begin
        s = s + n[i] * cw[i];
        nsq = nsq + 256'(n[i] * n[i]);
      end
      s_mag = (s < 0) ? 256'(-s) : 256'(s);
      if (nsq > SHORT_NSQ) begin
        r2 = 256'(rad) * 256'(rad);
        lhs = s_mag * s_mag;
        rhs = r2 * nsq;
        outside = (s < 0) && (lhs > rhs);
      end else begin
        // degenerate plane: compare the raw signed distance with the radius
        outside = (s < 0) && (s_mag > (256'(rad) << FRAC_BITS_DEF));
      end
      if (outside) seen = 1'b0;
    end
    return seen;
  endfunction

  always @(posedge clk) begin : watch
    bit want;
    if (rst) begin
      visible_q.delete();
      for (int i = 0; i < NUM_CFG; i++) matrix_regs[i] = '0;
      fail_count = 0;
    end else begin
      if (cfg_we) matrix_regs[cfg_index] = cfg_wdata;
      if (result.valid && result.ready) begin
        if (visible_q.size() == 0) begin
          if (fail_count < 10) $display("%0t: result item with nothing expected, visible=%0b",
                                        $time, result.visible);
          fail_count++;
        end else begin
          want = visible_q.pop_front();
          if (result.visible !== want) begin
            if (fail_count < 10) $display("%0t: visible mismatch, expected %0b got %0b",
                                          $time, want, result.visible);
            fail_count++;
          end
        end
      end
      if (sphere.valid && sphere.ready) begin
        visible_q.push_back(sphere_in_view(sphere.center_x, sphere.center_y,
                                           sphere.center_z, sphere.sphere_radius));
      end
    end
    pending = visible_q.size();
  end

endmodule

[tb/tb_top.sv]
// testbench top: clock, reset, matrix programming, sphere stimulus and result back-pressure
`timescale 1ns / 100ps

module tb_top import fsc_pkg::*; ();

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COL0_ROWS01, CFG_COL0_ROWS23, CFG_COL1_ROWS01, CFG_COL1_ROWS23,
    CFG_COL2_ROWS01, CFG_COL2_ROWS23, CFG_COL3_ROWS01, CFG_COL3_ROWS23
  } cfg_reg_e;

  typedef enum int {MAT_NEAR_DIAG, MAT_MODERATE, MAT_SHORT_MIX, MAT_FULL} matrix_kind_e;

  localparam int ONE = 1 << FRAC_BITS_DEF;
  localparam logic signed [COORD_W-1:0] C_MIN = 32'sh8000_0000;
  localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7fff_ffff;
  localparam logic [RAD_W-1:0] R_MAX = '1;
  localparam int HOLD_CYCLES = 60;
  localparam int RANDOM_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 75;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  int                   pending;
  int                   fail_count;
  bit                   steady;
  bit                   hold_req;

  fsc_in_if  sphere_ch ();
  fsc_out_if result_ch ();

  frustum_sphere_cull_top dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .sphere_in  (sphere_ch),
    .result_out (result_ch)
  );

  fsc_cull_checker cull_chk (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .sphere     (sphere_ch),
    .result     (result_ch),
    .pending    (pending),
    .fail_count (fail_count)
  );

  always #10 clk = ~clk;

  function automatic int gap_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (steady || pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic mat_t random_matrix(matrix_kind_e kind);
    mat_t m;
    int   k;
    k = $urandom_range(0, NUM_AXES - 1);
    for (int col = 0; col < MAT_DIM; col++) begin
      for (int row = 0; row < MAT_DIM; row++) begin
        case (kind)
          MAT_FULL:     m[col][row] = $urandom;
          MAT_MODERATE: m[col][row] = $urandom_range(0, 4 * ONE) - 2 * ONE;
          default: begin
            m[col][row] = (col == row) ? $urandom_range(ONE / 2, 2 * ONE)
                                       : $urandom_range(0, ONE / 2) - ONE / 4;
          end
        endcase
      end
    end
    // zero the w row and one axis row so two planes collapse to zero length
    if (kind == MAT_SHORT_MIX) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        m[i][3] = '0;
        m[i][k] = '0;
      end
    end
    return m;
  endfunction

  task automatic write_reg(cfg_reg_e idx, logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  task automatic load_matrix(mat_t m);
    write_reg(CFG_COL0_ROWS01, {m[0][1], m[0][0]});
    write_reg(CFG_COL0_ROWS23, {m[0][3], m[0][2]});
    write_reg(CFG_COL1_ROWS01, {m[1][1], m[1][0]});
    write_reg(CFG_COL1_ROWS23, {m[1][3], m[1][2]});
    write_reg(CFG_COL2_ROWS01, {m[2][1], m[2][0]});
    write_reg(CFG_COL2_ROWS23, {m[2][3], m[2][2]});
    write_reg(CFG_COL3_ROWS01, {m[3][1], m[3][0]});
    write_reg(CFG_COL3_ROWS23, {m[3][3], m[3][2]});
    cfg_we <= 1'b0;
  endtask

  task automatic send_sphere(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                             logic signed [COORD_W-1:0] z, logic [RAD_W-1:0] r);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      sphere_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sphere_ch.valid         <= 1'b1;
    sphere_ch.center_x      <= x;
    sphere_ch.center_y      <= y;
    sphere_ch.center_z      <= z;
    sphere_ch.sphere_radius <= r;
    @(posedge clk);
    while (!sphere_ch.ready) @(posedge clk);
  endtask

  task automatic send_random(bit full_range);
    logic signed [COORD_W-1:0] x, y, z;
    logic [RAD_W-1:0]          r;
    if (full_range) begin
      x = $urandom;
      y = $urandom;
      z = $urandom;
      r = RAD_W'($urandom);
    end else begin
      x = $urandom_range(0, 12 * ONE) - 6 * ONE;
      y = $urandom_range(0, 12 * ONE) - 6 * ONE;
      z = $urandom_range(0, 12 * ONE) - 6 * ONE;
      r = RAD_W'($urandom_range(0, 4 * ONE));
    end
    send_sphere(x, y, z, r);
  endtask

  // idle between phases once every result is back
  task automatic drain();
    sphere_ch.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (PIPE_DEPTH) @(posedge clk);
  endtask

  // result side back-pressure
  initial begin
    result_ch.ready <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      if (hold_req) begin
        result_ch.ready <= 1'b0;
        hold_req = 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (steady) begin
        result_ch.ready <= 1'b1;
        @(posedge clk);
      end else begin
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          result_ch.ready <= 1'b1;
          repeat ($urandom_range(1, 12)) @(posedge clk);
        end else if (pick < 95) begin
          result_ch.ready <= 1'b0;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else begin
          result_ch.ready <= 1'b0;
          repeat ($urandom_range(10, 40)) @(posedge clk);
        end
      end
    end
  end

  initial begin
    mat_t         m;
    matrix_kind_e plan [RANDOM_PHASES];
    plan = '{MAT_NEAR_DIAG, MAT_MODERATE, MAT_SHORT_MIX, MAT_NEAR_DIAG, MAT_FULL, MAT_MODERATE};
    steady   = 1'b0;
    hold_req = 1'b0;
    rst                     <= 1'b1;
    cfg_we                  <= 1'b0;
    cfg_index               <= '0;
    cfg_wdata               <= '0;
    sphere_ch.valid         <= 1'b0;
    sphere_ch.center_x      <= '0;
    sphere_ch.center_y      <= '0;
    sphere_ch.center_z      <= '0;
    sphere_ch.sphere_radius <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero matrix after reset: everything passes
    send_sphere(C_MIN, C_MIN, C_MIN, 0);
    send_sphere(C_MAX, C_MAX, C_MAX, R_MAX);
    send_sphere(0, 0, 0, 0);
    send_sphere(C_MIN, C_MAX, 0, R_MAX);
    drain();

    // identity: unit cube in clip space
    m = '0;
    for (int i = 0; i < MAT_DIM; i++) m[i][i] = ONE;
    load_matrix(m);
    send_sphere(0, 0, 0, 0);
    send_sphere(-ONE, 0, 0, 0);
    send_sphere(-3 * ONE, 0, 0, 2 * ONE);
    send_sphere(-3 * ONE, 0, 0, 2 * ONE - 1);
    send_sphere(3 * ONE, 0, 0, ONE);
    send_sphere(0, -5 * ONE, 0, ONE);
    send_sphere(0, 5 * ONE, 0, 4 * ONE);
    send_sphere(0, 0, -2 * ONE, ONE / 2);
    send_sphere(0, 0, ONE + ONE / 2, ONE / 2);
    send_sphere(C_MIN, C_MIN, C_MIN, R_MAX);
    send_sphere(C_MAX, C_MAX, C_MAX, 0);
    send_sphere(C_MIN, C_MAX, C_MIN, R_MAX);
    drain();

    // every plane has zero length and offset -1.0
    m = '0;
    m[3][3] = -ONE;
    load_matrix(m);
    send_sphere(0, 0, 0, ONE - 1);
    send_sphere(0, 0, 0, ONE);
    send_sphere(C_MAX, C_MIN, 0, 0);
    send_sphere(0, 0, 0, ONE + ONE / 8);
    drain();

    // extreme matrices
    m = {16{32'h7fff_ffff}};
    load_matrix(m);
    send_sphere(0, 0, 0, 0);
    send_sphere(C_MIN, C_MIN, C_MIN, R_MAX);
    drain();
    m = {16{32'h8000_0000}};
    load_matrix(m);
    send_sphere(0, 0, 0, 0);
    send_sphere(C_MAX, C_MAX, C_MAX, R_MAX);
    drain();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      load_matrix(random_matrix(plan[ph]));
      // one phase runs without gaps and with a long receiver hold-off
      if (ph == 3) begin
        steady   = 1'b1;
        hold_req = 1'b1;
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_random(plan[ph] == MAT_FULL || $urandom_range(0, 9) == 0);
      end
      drain();
      steady = 1'b0;
    end

    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule
